### rtl/core/mcwt_pkg.sv
// ----------------------------------------------------------------------------
// mcwt_pkg
// Shared types and constants for the multi-channel watchdog table.
// ----------------------------------------------------------------------------
`default_nettype none

package mcwt_pkg;

   // default sizing
   localparam int MCWT_CHANNELS   = 16;
   localparam int MCWT_TIME_WIDTH = 32;

   // fixed field widths on the ports
   localparam int MCWT_MODE_W  = 2;
   localparam int MCWT_CHAN_W  = 4;
   localparam int MCWT_STAMP_W = 32;

   // command queue depth between front and back
   localparam int MCWT_QUEUE_DEPTH = 2;

   // request modes
   localparam logic [MCWT_MODE_W-1:0] OP_CHECK = 2'd0;
   localparam logic [MCWT_MODE_W-1:0] OP_START = 2'd1;
   localparam logic [MCWT_MODE_W-1:0] OP_STOP  = 2'd2;
   localparam logic [MCWT_MODE_W-1:0] OP_KICK  = 2'd3;

   // result kinds
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // classified command control word
   typedef struct packed {
      logic [MCWT_MODE_W-1:0] op;
      logic                   in_range;
      logic [MCWT_CHAN_W-1:0] channel;
   } mcwt_ctrl_type;

   localparam int MCWT_CTRL_W = $bits(mcwt_ctrl_type);

endpackage

`default_nettype wire

### rtl/core/mcwt_front.sv
// ----------------------------------------------------------------------------
// mcwt_front
// Request intake: decodes the mode, range-checks the channel, trims the
// time fields to the table width and registers the command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcwt_front
   import mcwt_pkg::*;
#(
   parameter int CHANNELS   = MCWT_CHANNELS,
   parameter int TIME_WIDTH = MCWT_TIME_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [MCWT_MODE_W-1:0]  req_mode,
   input  wire logic [MCWT_CHAN_W-1:0]  req_channel,
   input  wire logic [MCWT_STAMP_W-1:0] req_timeout,
   input  wire logic [MCWT_STAMP_W-1:0] req_stamp,
   output      logic                    cmd_valid,
   input  wire logic                    cmd_ready,
   output      mcwt_ctrl_type           cmd_ctrl,
   output      logic [TIME_WIDTH-1:0]   cmd_timeout,
   output      logic [TIME_WIDTH-1:0]   cmd_stamp
);

   logic                  hold_vld_ff, hold_vld_in;
   mcwt_ctrl_type         hold_ctrl_ff, hold_ctrl_in;
   logic [TIME_WIDTH-1:0] hold_tmo_ff, hold_tmo_in;
   logic [TIME_WIDTH-1:0] hold_stamp_ff, hold_stamp_in;
   logic                  take;

   // holding stage frees up when empty or draining into the queue
   assign req_ready = !hold_vld_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   // classify the incoming beat
   always_comb begin
      hold_ctrl_in.op       = req_mode;
      hold_ctrl_in.channel  = req_channel;
      hold_ctrl_in.in_range = ({{(32-MCWT_CHAN_W){1'b0}}, req_channel} < 32'(CHANNELS));
      hold_tmo_in           = TIME_WIDTH'(req_timeout);
      hold_stamp_in         = TIME_WIDTH'(req_stamp);
   end

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (take) begin
         hold_vld_in = 1'b1;
      end else if (cmd_ready) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ctrl_ff  <= hold_ctrl_in;
         hold_tmo_ff   <= hold_tmo_in;
         hold_stamp_ff <= hold_stamp_in;
      end
   end

   assign cmd_valid   = hold_vld_ff;
   assign cmd_ctrl    = hold_ctrl_ff;
   assign cmd_timeout = hold_tmo_ff;
   assign cmd_stamp   = hold_stamp_ff;

endmodule

`default_nettype wire

### rtl/core/mcwt_queue.sv
// ----------------------------------------------------------------------------
// mcwt_queue
// Small FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcwt_queue
   import mcwt_pkg::*;
#(
   parameter int WIDTH = MCWT_CTRL_W,
   parameter int DEPTH = MCWT_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             pop_valid,
   input  wire logic             pop_ready,
   output      logic [WIDTH-1:0] pop_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slots [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mcwt_back.sv
// ----------------------------------------------------------------------------
// mcwt_back
// Channel table and executor: applies start/stop/kick to the table and
// walks one channel per cycle on a check unless stalled, reporting timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module mcwt_back
   import mcwt_pkg::*;
#(
   parameter int CHANNELS   = MCWT_CHANNELS,
   parameter int TIME_WIDTH = MCWT_TIME_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output      logic                    q_pop,
   input  wire mcwt_ctrl_type           q_ctrl,
   input  wire logic [TIME_WIDTH-1:0]   q_timeout,
   input  wire logic [TIME_WIDTH-1:0]   q_stamp,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_kind,
   output      logic [MCWT_CHAN_W-1:0]  rsp_channel_out,
   output      logic                    rsp_ok,
   output      logic [MCWT_STAMP_W-1:0] rsp_last_reset_time,
   output      logic                    rsp_last
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // table storage
   logic [TIME_WIDTH-1:0] dur_mem [CHANNELS];
   logic [TIME_WIDTH-1:0] lrt_mem [CHANNELS];
   logic [CHANNELS-1:0]   active_ff, active_in;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;

   // read stage
   logic                  rd_vld_ff, rd_vld_in;
   logic [CH_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                  rd_act_ff, rd_act_in;
   logic [TIME_WIDTH-1:0] rd_dur_ff, rd_lrt_ff;

   // report waiting to learn whether it is the final one
   logic                   pend_vld_ff, pend_vld_in;
   logic [MCWT_CHAN_W-1:0] pend_ch_ff, pend_ch_in;
   logic [TIME_WIDTH-1:0]  pend_lrt_ff, pend_lrt_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [MCWT_CHAN_W-1:0]  rsp_ch_ff, rsp_ch_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [MCWT_STAMP_W-1:0] rsp_lrt_ff, rsp_lrt_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    out_load;

   logic                  out_free, hit, adv, issue_done, scan_end, rd_en;
   logic [CH_W-1:0]       ch_idx, rd_addr;
   logic [TIME_WIDTH:0]   deadline;
   logic                  dur_we, lrt_we;
   logic [TIME_WIDTH-1:0] dur_wdata;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ch_idx     = CH_W'(q_ctrl.channel);
   assign rd_addr    = scan_idx_ff[CH_W-1:0];
   assign issue_done = (scan_idx_ff == CNT_W'(CHANNELS));

   // expiry test at one bit above the time width
   assign deadline = {1'b0, rd_lrt_ff} + {1'b0, rd_dur_ff};
   assign hit      = rd_vld_ff && rd_act_ff && (deadline < {1'b0, now_ff});

   // a second hit has to push the held report out first
   assign adv      = !(hit && pend_vld_ff) || out_free;
   assign scan_end = (state_ff == ST_SCAN) && issue_done && !rd_vld_ff;
   assign rd_en    = (state_ff == ST_SCAN) && adv && !issue_done;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && out_free;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      now_in      = now_ff;
      active_in   = active_ff;
      rd_vld_in   = rd_vld_ff;
      rd_idx_in   = rd_idx_ff;
      rd_act_in   = rd_act_ff;
      pend_vld_in = pend_vld_ff;
      pend_ch_in  = pend_ch_ff;
      pend_lrt_in = pend_lrt_ff;
      dur_we      = 1'b0;
      lrt_we      = 1'b0;
      dur_wdata   = q_timeout;
      out_load    = 1'b0;
      rsp_kind_in = KIND_ACK;
      rsp_ch_in   = q_ctrl.channel;
      rsp_ok_in   = 1'b0;
      rsp_lrt_in  = '0;
      rsp_last_in = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_ctrl.op == OP_CHECK) begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  now_in      = q_stamp;
                  pend_vld_in = 1'b0;
                  rd_vld_in   = 1'b0;
               end else begin
                  out_load = 1'b1;
                  unique case (q_ctrl.op)
                     OP_START: begin
                        if (q_ctrl.in_range && !active_ff[ch_idx]) begin
                           active_in[ch_idx] = 1'b1;
                           dur_we            = 1'b1;
                           lrt_we            = 1'b1;
                           rsp_ok_in         = 1'b1;
                        end
                     end
                     OP_STOP: begin
                        if (q_ctrl.in_range && active_ff[ch_idx]) begin
                           active_in[ch_idx] = 1'b0;
                           rsp_ok_in         = 1'b1;
                        end
                     end
                     OP_KICK: begin
                        if (q_ctrl.in_range) begin
                           if (!active_ff[ch_idx]) begin
                              active_in[ch_idx] = 1'b1;
                              dur_we            = 1'b1;
                              dur_wdata         = '0;
                           end
                           lrt_we    = 1'b1;
                           rsp_ok_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            // issue one table read per cycle while the walk can advance
            if (adv) begin
               if (!issue_done) begin
                  rd_vld_in   = 1'b1;
                  rd_idx_in   = rd_addr;
                  rd_act_in   = active_ff[rd_addr];
                  scan_idx_in = scan_idx_ff + 1'b1;
               end else begin
                  rd_vld_in = 1'b0;
               end
               // evaluate the entry held in the read stage
               if (hit) begin
                  if (pend_vld_ff) begin
                     out_load    = 1'b1;
                     rsp_kind_in = KIND_REPORT;
                     rsp_ch_in   = pend_ch_ff;
                     rsp_ok_in   = 1'b1;
                     rsp_lrt_in  = MCWT_STAMP_W'(pend_lrt_ff);
                     rsp_last_in = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_ch_in  = MCWT_CHAN_W'(rd_idx_ff);
                  pend_lrt_in = rd_lrt_ff;
               end
            end
            // walk finished: flush held report as final, or report empty
            if (scan_end && out_free) begin
               out_load    = 1'b1;
               state_in    = ST_IDLE;
               pend_vld_in = 1'b0;
               if (pend_vld_ff) begin
                  rsp_kind_in = KIND_REPORT;
                  rsp_ch_in   = pend_ch_ff;
                  rsp_ok_in   = 1'b1;
                  rsp_lrt_in  = MCWT_STAMP_W'(pend_lrt_ff);
               end else begin
                  rsp_kind_in = KIND_ACK;
                  rsp_ch_in   = '0;
               end
               rsp_last_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rd_idx_ff   <= rd_idx_in;
      rd_act_ff   <= rd_act_in;
      pend_ch_ff  <= pend_ch_in;
      pend_lrt_ff <= pend_lrt_in;
      if (out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_ch_ff   <= rsp_ch_in;
         rsp_ok_ff   <= rsp_ok_in;
         rsp_lrt_ff  <= rsp_lrt_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // timeout and last-reset memories, registered read
   always_ff @(posedge clock) begin
      if (dur_we) begin
         dur_mem[ch_idx] <= dur_wdata;
      end
      if (lrt_we) begin
         lrt_mem[ch_idx] <= q_stamp;
      end
      if (rd_en) begin
         rd_dur_ff <= dur_mem[rd_addr];
         rd_lrt_ff <= lrt_mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_channel_out     = rsp_ch_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_last_reset_time = rsp_lrt_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/multi_channel_watchdog_table_core.sv
// ----------------------------------------------------------------------------
// multi_channel_watchdog_table_core
// Table of watchdog channels: start, stop and kick channels, and check
// all active channels for expiry against a time stamp.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   req     | in  | req_valid/req_ready  | mode, channel, timeout, stamp
//   rsp     | out | rsp_valid/rsp_ready  | kind, channel_out, ok,
//           |     |                      | last_reset_time, last
//
// Start, stop and kick are applied in the back end when popped; the result
// beat passes the front register, the queue and the back output register.
// A check walks the table through the single memory read port, one channel
// per cycle unless stalled as below.
// Reset clears the active map; no clearing pass is needed.
// A report stalls the walk only when the output register is still full
// and a further expired channel is found; the closing beat waits for the
// output register. The front keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_watchdog_table_core
   import mcwt_pkg::*;
#(
   parameter int CHANNELS   = MCWT_CHANNELS,
   parameter int TIME_WIDTH = MCWT_TIME_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [MCWT_MODE_W-1:0]  req_mode,
   input  wire logic [MCWT_CHAN_W-1:0]  req_channel,
   input  wire logic [MCWT_STAMP_W-1:0] req_timeout,
   input  wire logic [MCWT_STAMP_W-1:0] req_stamp,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_kind,
   output      logic [MCWT_CHAN_W-1:0]  rsp_channel_out,
   output      logic                    rsp_ok,
   output      logic [MCWT_STAMP_W-1:0] rsp_last_reset_time,
   output      logic                    rsp_last
);

   localparam int QW = MCWT_CTRL_W + 2 * TIME_WIDTH;

   logic                  f_valid, f_ready;
   mcwt_ctrl_type         f_ctrl;
   logic [TIME_WIDTH-1:0] f_timeout, f_stamp;

   logic                  q_valid, q_pop;
   logic [QW-1:0]         q_data;
   mcwt_ctrl_type         q_ctrl;
   logic [TIME_WIDTH-1:0] q_timeout, q_stamp;

   mcwt_front #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_channel (req_channel),
      .req_timeout (req_timeout),
      .req_stamp   (req_stamp),
      .cmd_valid   (f_valid),
      .cmd_ready   (f_ready),
      .cmd_ctrl    (f_ctrl),
      .cmd_timeout (f_timeout),
      .cmd_stamp   (f_stamp)
   );

   mcwt_queue #(
      .WIDTH (QW),
      .DEPTH (MCWT_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_ctrl, f_timeout, f_stamp}),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_data)
   );

   // unpack queue entry
   assign q_ctrl    = q_data[QW-1 -: MCWT_CTRL_W];
   assign q_timeout = q_data[2*TIME_WIDTH-1 -: TIME_WIDTH];
   assign q_stamp   = q_data[TIME_WIDTH-1:0];

   mcwt_back #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_pop               (q_pop),
      .q_ctrl              (q_ctrl),
      .q_timeout           (q_timeout),
      .q_stamp             (q_stamp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_channel_out     (rsp_channel_out),
      .rsp_ok              (rsp_ok),
      .rsp_last_reset_time (rsp_last_reset_time),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/mcwt_checker.sv
// ----------------------------------------------------------------------------
// mcwt_checker
// Port-level checks on the watchdog table's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcwt_checker
   import mcwt_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_kind,
   input wire logic [MCWT_CHAN_W-1:0]  rsp_channel_out,
   input wire logic                    rsp_ok,
   input wire logic [MCWT_STAMP_W-1:0] rsp_last_reset_time,
   input wire logic                    rsp_last
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_channel_out) && $stable(rsp_ok)
         && $stable(rsp_last_reset_time) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // timeout reports always carry ok
   a_report_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REPORT) |-> rsp_ok)
      else $error("timeout report without ok");

   // acknowledgments and empty checks are single-beat
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ACK) |-> rsp_last)
      else $error("acknowledgment not marked last");

   // acknowledgments carry no time
   a_ack_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ACK) |-> (rsp_last_reset_time == '0))
      else $error("acknowledgment carries a reset time");

endmodule

bind multi_channel_watchdog_table_core mcwt_checker u_mcwt_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_kind            (rsp_kind),
   .rsp_channel_out     (rsp_channel_out),
   .rsp_ok              (rsp_ok),
   .rsp_last_reset_time (rsp_last_reset_time),
   .rsp_last            (rsp_last)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb - multi-channel watchdog table testbench
// Drives start, stop, kick and check requests into the watchdog table and
// predicts every response beat from a local copy of the channel table.
// Directed tests cover acks, failures, the 33-bit expiry compare and a check
// that reports all sixteen channels. A long output hold-off and random
// traffic follow, with idle bursts on both sides and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcwt_pkg::*;

   localparam int NUM_CH      = MCWT_CHANNELS;
   localparam time RUN_LIMIT  = 2ms;
   localparam int MAX_LOGGED  = 20;

   // one response beat
   typedef struct packed {
      logic                    kind;
      logic [MCWT_CHAN_W-1:0]  chan;
      logic                    ok;
      logic [MCWT_STAMP_W-1:0] lrt;
      logic                    last;
   } wd_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic [MCWT_MODE_W-1:0]  req_mode    = OP_CHECK;
   logic [MCWT_CHAN_W-1:0]  req_channel = '0;
   logic [MCWT_STAMP_W-1:0] req_timeout = '0;
   logic [MCWT_STAMP_W-1:0] req_stamp   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic                    rsp_kind;
   logic [MCWT_CHAN_W-1:0]  rsp_channel_out;
   logic                    rsp_ok;
   logic [MCWT_STAMP_W-1:0] rsp_last_reset_time;
   logic                    rsp_last;

   // local copy of the channel table
   logic                    chan_active [NUM_CH];
   logic [MCWT_STAMP_W-1:0] chan_timeout [NUM_CH];
   logic [MCWT_STAMP_W-1:0] chan_kicked_at [NUM_CH];

   wd_beat_type pending_beats [$];

   // idle control, written by the stimulus with nonblocking assignments
   logic quiet_tail = 1'b0;
   logic hold_go    = 1'b0;
   int   hold_len   = 0;

   // owned by the output ready process
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   idle_left = 0;

   // random traffic time base
   logic [MCWT_STAMP_W-1:0] time_base;

   int n_errors  = 0;
   int n_items   = 0;
   int n_checks  = 0;
   int n_reports = 0;
   int n_beats   = 0;
   int n_stalls  = 0;

   multi_channel_watchdog_table_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_channel         (req_channel),
      .req_timeout         (req_timeout),
      .req_stamp           (req_stamp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_channel_out     (rsp_channel_out),
      .rsp_ok              (rsp_ok),
      .rsp_last_reset_time (rsp_last_reset_time),
      .rsp_last            (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // deadline compared one bit wider than the time stamps
   function automatic logic chan_expired(int idx, logic [MCWT_STAMP_W-1:0] now);
      return chan_active[idx] &&
             (({1'b0, chan_kicked_at[idx]} + {1'b0, chan_timeout[idx]}) < {1'b0, now});
   endfunction

   task automatic predict_watchdog(input logic [MCWT_MODE_W-1:0] mode,
                                   input logic [MCWT_CHAN_W-1:0] ch,
                                   input logic [MCWT_STAMP_W-1:0] tmo,
                                   input logic [MCWT_STAMP_W-1:0] stamp);
      int          hits;
      int          seen;
      logic        ok;
      wd_beat_type b;
      hits = 0;
      seen = 0;
      ok   = 1'b0;
      if (mode == OP_CHECK) begin
         n_checks++;
         for (int i = 0; i < NUM_CH; i++)
            if (chan_expired(i, stamp)) hits++;
         if (hits == 0) begin
            b = '{kind: KIND_ACK, chan: '0, ok: 1'b0, lrt: '0, last: 1'b1};
            pending_beats.push_back(b);
         end else begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (chan_expired(i, stamp)) begin
                  seen++;
                  b = '{kind: KIND_REPORT, chan: i[MCWT_CHAN_W-1:0], ok: 1'b1,
                        lrt: chan_kicked_at[i], last: (seen == hits)};
                  pending_beats.push_back(b);
               end
            end
            n_reports += hits;
         end
      end else begin
         case (mode)
            OP_START: begin
               if (!chan_active[ch]) begin
                  chan_active[ch]    = 1'b1;
                  chan_timeout[ch]   = tmo;
                  chan_kicked_at[ch] = stamp;
                  ok = 1'b1;
               end
            end
            OP_STOP: begin
               if (chan_active[ch]) begin
                  chan_active[ch] = 1'b0;
                  ok = 1'b1;
               end
            end
            default: begin
               // kick arms an idle channel with zero timeout
               if (!chan_active[ch]) begin
                  chan_active[ch]  = 1'b1;
                  chan_timeout[ch] = '0;
               end
               chan_kicked_at[ch] = stamp;
               ok = 1'b1;
            end
         endcase
         b = '{kind: KIND_ACK, chan: ch, ok: ok, lrt: '0, last: 1'b1};
         pending_beats.push_back(b);
      end
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (n_errors < MAX_LOGGED)
         $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   task automatic check_beat();
      wd_beat_type w;
      if (pending_beats.size() == 0) begin
         flag_mismatch("beat with nothing pending, channel", 32'(rsp_channel_out), 0);
      end else begin
         w = pending_beats.pop_front();
         if (rsp_kind !== w.kind) flag_mismatch("kind", 32'(rsp_kind), 32'(w.kind));
         if (rsp_channel_out !== w.chan)
            flag_mismatch("channel_out", 32'(rsp_channel_out), 32'(w.chan));
         if (rsp_ok !== w.ok) flag_mismatch("ok", 32'(rsp_ok), 32'(w.ok));
         if (rsp_last_reset_time !== w.lrt)
            flag_mismatch("last_reset_time", rsp_last_reset_time, w.lrt);
         if (rsp_last !== w.last) flag_mismatch("last", 32'(rsp_last), 32'(w.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) n_stalls++;
         if (rsp_valid && rsp_ready) begin
            n_beats++;
            check_beat();
         end
      end
   end

   // ------------------------------------------------------------------------
   // output ready: long hold-off on request, else random idle bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         idle_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers; every task is entered and left on a rising edge
   // ------------------------------------------------------------------------

   task automatic send_request(input logic [MCWT_MODE_W-1:0] mode,
                               input logic [MCWT_CHAN_W-1:0] ch,
                               input logic [MCWT_STAMP_W-1:0] tmo,
                               input logic [MCWT_STAMP_W-1:0] stamp);
      int gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_channel <= ch;
      req_timeout <= tmo;
      req_stamp   <= stamp;
      do @(posedge clock); while (!req_ready);
      predict_watchdog(mode, ch, tmo, stamp);
      n_items++;
   endtask

   // sender pause until every pending beat has come back
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_beats.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // random channel, biased toward a wanted active state
   function automatic logic [MCWT_CHAN_W-1:0] pick_channel(logic want_active);
      logic [MCWT_CHAN_W-1:0] c;
      c = MCWT_CHAN_W'($urandom_range(0, NUM_CH - 1));
      for (int tries = 0; tries < 8 && chan_active[c] != want_active; tries++)
         c = MCWT_CHAN_W'($urandom_range(0, NUM_CH - 1));
      return c;
   endfunction

   task automatic send_random_request();
      int                      r;
      logic [MCWT_MODE_W-1:0]  mode;
      logic [MCWT_CHAN_W-1:0]  ch;
      logic [MCWT_STAMP_W-1:0] tmo;
      logic [MCWT_STAMP_W-1:0] stamp;
      logic [MCWT_STAMP_W:0]   deadline;
      r = $urandom_range(0, 99);
      if (r < 35)      mode = OP_CHECK;
      else if (r < 55) mode = OP_START;
      else if (r < 77) mode = OP_STOP;
      else             mode = OP_KICK;

      case (mode)
         OP_START: ch = pick_channel($urandom_range(0, 4) == 0);
         OP_STOP:  ch = pick_channel($urandom_range(0, 4) != 0);
         default:  ch = MCWT_CHAN_W'($urandom_range(0, NUM_CH - 1));
      endcase

      r = $urandom_range(0, 9);
      if (r < 6)      tmo = $urandom_range(0, 64);
      else if (r < 9) tmo = $urandom;
      else            tmo = ($urandom_range(0, 1) != 0) ? '1 : '0;

      time_base += $urandom_range(0, 48);
      stamp = ($urandom_range(0, 6) == 0) ? $urandom : time_base;

      // checks often land right around an active channel's deadline
      if (mode == OP_CHECK && $urandom_range(0, 1) != 0) begin
         ch = pick_channel(1'b1);
         deadline = {1'b0, chan_kicked_at[ch]} + {1'b0, chan_timeout[ch]};
         if (chan_active[ch] && !deadline[MCWT_STAMP_W])
            stamp = deadline[MCWT_STAMP_W-1:0] + $urandom_range(0, 4) - 2;
      end
      send_request(mode, ch, tmo, stamp);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // acks for each mode, both outcomes
   task automatic test_acks();
      send_request(OP_CHECK, 4'd0,  32'h0,        32'hFFFF_FFFF); // empty table
      send_request(OP_STOP,  4'd5,  32'h0,        32'h0);         // stop idle: fails
      send_request(OP_START, 4'd0,  32'h0,        32'h0);
      send_request(OP_START, 4'd0,  32'h5,        32'h9);         // already running
      send_request(OP_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_KICK,  4'd7,  32'hFFFF_FFFF, 32'd100);      // arms with zero timeout
      send_request(OP_KICK,  4'd0,  32'h1234_5678, 32'd200);
      send_request(OP_STOP,  4'd7,  32'h0,        32'h0);
      send_request(OP_STOP,  4'd7,  32'h0,        32'h0);         // now idle: fails
   endtask

   // deadline equal to stamp, deadline past 32 bits, empty and multi-report checks
   task automatic test_expiry_edges();
      send_request(OP_START, 4'd3, 32'h8000_0000, 32'h8000_0000); // deadline 2^32
      send_request(OP_START, 4'd9, 32'd10,        32'd90);        // deadline 100
      send_request(OP_CHECK, 4'd9, 32'h0, 32'd100);
      send_request(OP_CHECK, 4'd9, 32'h0, 32'd101);
      send_request(OP_CHECK, 4'd0, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_CHECK, 4'd0, 32'h0, 32'h0);
   endtask

   // every channel expired in one check
   task automatic test_full_table();
      send_request(OP_STOP, 4'd15, 32'h0, 32'h0);
      send_request(OP_STOP, 4'd3,  32'h0, 32'h0);
      for (int i = 0; i < NUM_CH; i++)
         send_request(OP_KICK, i[MCWT_CHAN_W-1:0], 32'h0, {i[3:0], 28'h0AB_CDEF});
      send_request(OP_CHECK, 4'd0, 32'h0, 32'hFFFF_FFFF);
   endtask

   // output held off while requests keep coming, then a full drain
   task automatic test_backpressure();
      hold_len <= 150;
      hold_go  <= ~hold_go;
      for (int i = 0; i < 20; i++) begin
         if (i % 3 == 2)
            send_request(OP_KICK, MCWT_CHAN_W'($urandom_range(0, NUM_CH - 1)),
                         $urandom, $urandom);
         else
            send_request(OP_CHECK, 4'd0, 32'h0, 32'hFFFF_FFFF);
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input logic quiet);
      quiet_tail <= quiet;
      repeat (count) send_random_request();
   endtask

   // ------------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         chan_active[i]    = 1'b0;
         chan_timeout[i]   = '0;
         chan_kicked_at[i] = '0;
      end
      time_base = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_acks();
      test_expiry_edges();
      test_full_table();
      test_backpressure();
      test_random_traffic(200, 1'b0);
      test_random_traffic(56, 1'b1);

      wait_for_results();
      repeat (NUM_CH + 8) @(posedge clock);
      if (pending_beats.size() != 0)
         flag_mismatch("beats never returned, count", pending_beats.size(), 0);

      $display("Covered %0d requests, %0d of them checks, giving %0d beats (%0d expiry reports).",
               n_items, n_checks, n_beats, n_reports);
      $display("Request side stalled %0d cycles; %0d mismatches.", n_stalls, n_errors);
      if (n_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // run time limit
   initial begin
      #RUN_LIMIT;
      $display("Timed out with %0d beats pending.", pending_beats.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
